### hw/rtl/alsc_pkg.sv
// shared types, constants and reset tables of the adaptive line sensor classifier
package alsc_pkg;

  localparam int SENSOR_COUNT_DEF = 4;
  localparam int WINDOW_DEPTH_DEF = 10;
  localparam int READING_BITS_DEF = 12;

  localparam int IDX_W = 2;
  localparam int PAT_W = 4;

  localparam int LOW_RESET [4]  = '{47, 344, 390, 675};
  localparam int HIGH_RESET [4] = '{1441, 872, 846, 955};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_MUL,
    ST_QMUL,
    ST_CORR,
    ST_FIN
  } state_e;

  function automatic int low_reset(int s);
    if (s < 4) begin
      return LOW_RESET[s[1:0]];
    end
    return 0;
  endfunction

  function automatic int high_reset(int s);
    if (s < 4) begin
      return HIGH_RESET[s[1:0]];
    end
    return 0;
  endfunction

endpackage

### hw/rtl/adaptive_line_sensor_classifier.sv
// top level of the adaptive line sensor classifier
// One request carries a sensor index and a reading. The block compares the
// reading with the midpoint of that sensor's low and high extremes, reports
// black when the reading is above it, and folds the reading into the high or
// low window of that sensor to adapt the matching extreme. For an in-range
// request the window ram is walked one entry per cycle through a single
// accumulator, then the mean is taken with a reciprocal multiply, a constant
// multiply and one correction step. A request for a sensor beyond
// SENSOR_COUNT skips the window walk and changes no state. Input stall is
// high from accept until the result is loaded into the output register; a
// result waiting there does not block the next accept.
module adaptive_line_sensor_classifier #(
  parameter int SENSOR_COUNT = alsc_pkg::SENSOR_COUNT_DEF,
  parameter int WINDOW_DEPTH = alsc_pkg::WINDOW_DEPTH_DEF,
  parameter int READING_BITS = alsc_pkg::READING_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [alsc_pkg::IDX_W-1:0] sensor_index_i,
  input  logic [READING_BITS-1:0]    reading_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       is_black_o,
  output logic [READING_BITS-1:0]    threshold_used_o,
  output logic [alsc_pkg::PAT_W-1:0] sensor_pattern_o,
  output logic                       pattern_changed_o
);

  import alsc_pkg::*;

  localparam int SIDX_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int RAM_D   = 2 * SENSOR_COUNT * WINDOW_DEPTH;
  localparam int ADDR_W  = $clog2(RAM_D);
  localparam int SUM_W   = READING_BITS + $clog2(WINDOW_DEPTH);
  localparam int PROD_W  = 2 * SUM_W;
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_W = SUM_W'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  state_e state_q, state_d;

  logic [READING_BITS-1:0] lo_q [SENSOR_COUNT];
  logic [READING_BITS-1:0] hi_q [SENSOR_COUNT];
  logic [SLOT_W-1:0]       lslot_q [SENSOR_COUNT];
  logic [SLOT_W-1:0]       hslot_q [SENSOR_COUNT];
  logic [RAM_D-1:0]        vld_q;
  logic [PAT_W-1:0]        pat_q;
  logic                    out_valid_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    pend_q;

  logic [IDX_W-1:0]        idx_q;
  logic [READING_BITS-1:0] rd_q;
  logic                    ok_q;
  logic [READING_BITS-1:0] thr_q;
  logic                    black_q;
  logic                    win_q;
  logic [READING_BITS-1:0] ext_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [SLOT_W-1:0]       pend_e_q;
  logic                    rd_vld_q;
  logic [SUM_W-1:0]        acc_q;
  logic [PROD_W-1:0]       prod_q;
  logic [SUM_W-1:0]        q0_q;
  logic [SUM_W-1:0]        qd_q;
  logic                    is_black_q;
  logic [READING_BITS-1:0] thr_out_q;
  logic [PAT_W-1:0]        pat_out_q;
  logic                    chg_q;

  logic [SIDX_W-1:0]       sidx;
  logic [READING_BITS:0]   mid_sum;
  logic [READING_BITS-1:0] thr;
  logic [ADDR_W-1:0]       raddr;
  logic [ADDR_W-1:0]       waddr;
  logic                    we;
  logic [READING_BITS-1:0] rdata;
  logic [READING_BITS-1:0] entry;
  logic [READING_BITS-1:0] val;
  logic [SUM_W-1:0]        rem;
  logic [SUM_W-1:0]        quot;
  logic [READING_BITS:0]   ext_sum;
  logic [READING_BITS-1:0] ext_new;
  logic [SLOT_W-1:0]       slot_next;
  logic [PAT_W-1:0]        pat_next;
  logic                    accept;
  logic                    out_free;

  function automatic logic [ADDR_W-1:0] win_addr(logic w, logic [SIDX_W-1:0] s,
                                                 logic [SLOT_W-1:0] e);
    return ADDR_W'(32'(w) * SENSOR_COUNT * WINDOW_DEPTH + 32'(s) * WINDOW_DEPTH
                   + 32'(e));
  endfunction

  assign sidx      = SIDX_W'(idx_q);
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign mid_sum   = {1'b0, lo_q[sidx]} + {1'b0, hi_q[sidx]};
  assign thr       = mid_sum[READING_BITS:1];
  assign raddr     = win_addr(win_q, sidx, cnt_q[SLOT_W-1:0]);
  assign waddr     = win_addr(win_q, sidx, pend_e_q);
  assign entry     = rd_vld_q ? rdata : '0;
  assign rem       = acc_q - qd_q;
  assign quot      = q0_q + ((rem >= DEPTH_W) ? SUM_W'(1) : SUM_W'(0));
  assign ext_sum   = {1'b0, ext_q} + {1'b0, quot[READING_BITS-1:0]};
  assign ext_new   = ext_sum[READING_BITS:1];
  assign slot_next = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);

  always_comb begin
    pat_next        = pat_q;
    pat_next[idx_q] = black_q;
  end

  // written slot takes the reading, empty entries take the extreme
  always_comb begin
    if (pend_e_q == slot_q) begin
      val = rd_q;
    end else if (entry == '0) begin
      val = ext_q;
    end else begin
      val = entry;
    end
    we = (state_q == ST_SCAN) && pend_q && ((pend_e_q == slot_q) || (entry == '0));
  end

  alsc_ram #(
    .WIDTH(READING_BITS),
    .DEPTH(RAM_D)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (val),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ok_q ? ST_SCAN : ST_FIN;
      end
      ST_SCAN: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_QMUL;
      ST_QMUL: state_d = ST_CORR;
      ST_CORR: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        lo_q[s]    <= READING_BITS'(low_reset(s));
        hi_q[s]    <= READING_BITS'(high_reset(s));
        lslot_q[s] <= '0;
        hslot_q[s] <= '0;
      end
      vld_q       <= '0;
      pat_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      unique case (state_q)
        ST_SETUP: begin
          cnt_q  <= '0;
          pend_q <= 1'b0;
        end
        ST_SCAN: begin
          if (cnt_q != CNT_LAST) begin
            cnt_q  <= cnt_q + CNT_W'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
        end
        ST_CORR: begin
          if (win_q) begin
            hi_q[sidx]    <= ext_new;
            hslot_q[sidx] <= slot_next;
          end else begin
            lo_q[sidx]    <= ext_new;
            lslot_q[sidx] <= slot_next;
          end
        end
        ST_FIN: begin
          if (out_free && ok_q) begin
            pat_q <= pat_next;
          end
        end
        default: ;
      endcase
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= sensor_index_i;
      rd_q  <= reading_i;
      ok_q  <= (32'(sensor_index_i) < SENSOR_COUNT);
    end
    if (state_q == ST_SETUP) begin
      thr_q   <= thr;
      black_q <= rd_q > thr;
      win_q   <= rd_q >= thr;
      ext_q   <= (rd_q >= thr) ? hi_q[sidx] : lo_q[sidx];
      slot_q  <= (rd_q >= thr) ? hslot_q[sidx] : lslot_q[sidx];
      acc_q   <= '0;
    end
    if (state_q == ST_SCAN) begin
      pend_e_q <= cnt_q[SLOT_W-1:0];
      rd_vld_q <= vld_q[raddr];
      if (pend_q) begin
        acc_q <= acc_q + SUM_W'(val);
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'(RECIP);
    end
    if (state_q == ST_QMUL) begin
      q0_q <= prod_q[PROD_W-1:SUM_W];
      qd_q <= prod_q[PROD_W-1:SUM_W] * DEPTH_W;
    end
    if ((state_q == ST_FIN) && out_free) begin
      is_black_q <= ok_q && black_q;
      thr_out_q  <= ok_q ? thr_q : '0;
      pat_out_q  <= ok_q ? pat_next : pat_q;
      chg_q      <= ok_q && (pat_next != pat_q);
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign is_black_o        = is_black_q;
  assign threshold_used_o  = thr_out_q;
  assign sensor_pattern_o  = pat_out_q;
  assign pattern_changed_o = chg_q;

endmodule

### hw/rtl/alsc_ram.sv
// generic single write port ram with registered read
module alsc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/alsc_checker.sv
// port level checks of the adaptive line sensor classifier and their binding
module alsc_checker #(
  parameter int READING_BITS = alsc_pkg::READING_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic                    is_black_o,
  input logic [READING_BITS-1:0] threshold_used_o
);

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // busy right after a request is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only comes out of a busy block
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

  // black needs a reading above the threshold
  a_black_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_black_o) |-> (threshold_used_o != {READING_BITS{1'b1}}))
    else $error("black reported at full scale threshold");

endmodule

bind adaptive_line_sensor_classifier alsc_checker #(
  .READING_BITS(READING_BITS)
) u_alsc_checker (.*);

### tb/alsc_verdict_checker.sv
// checker that predicts and compares classifier results for the line sensor testbench
`timescale 1ns / 100ps

module alsc_verdict_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_i,
  input  logic [alsc_pkg::IDX_W-1:0]             sensor_index_i,
  input  logic [alsc_pkg::READING_BITS_DEF-1:0]  reading_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_stall_i,
  input  logic                                   is_black_i,
  input  logic [alsc_pkg::READING_BITS_DEF-1:0]  threshold_used_i,
  input  logic [alsc_pkg::PAT_W-1:0]             sensor_pattern_i,
  input  logic                                   pattern_changed_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);

  localparam int SENSORS = alsc_pkg::SENSOR_COUNT_DEF;
  localparam int DEPTH   = alsc_pkg::WINDOW_DEPTH_DEF;
  localparam int RBITS   = alsc_pkg::READING_BITS_DEF;

  typedef struct packed {
    logic                        is_black;
    logic [RBITS-1:0]            threshold;
    logic [alsc_pkg::PAT_W-1:0]  pattern;
    logic                        changed;
  } sensor_verdict_t;

  sensor_verdict_t predicted_verdicts[$];

  int low_ext [SENSORS];
  int high_ext [SENSORS];
  int low_win [SENSORS][DEPTH];
  int high_win [SENSORS][DEPTH];
  int low_slot [SENSORS];
  int high_slot [SENSORS];
  logic [alsc_pkg::PAT_W-1:0] black_flags;
  logic [alsc_pkg::PAT_W-1:0] last_pattern;

  task automatic clear_sensor_state();
    for (int s = 0; s < SENSORS; s++) begin
      low_ext[s] = (s < 4) ? alsc_pkg::LOW_RESET[s] : 0;
      high_ext[s] = (s < 4) ? alsc_pkg::HIGH_RESET[s] : 0;
      low_slot[s] = 0;
      high_slot[s] = 0;
      for (int i = 0; i < DEPTH; i++) begin
        low_win[s][i] = 0;
        high_win[s][i] = 0;
      end
    end
    black_flags = '0;
    last_pattern = '0;
  endtask

  function automatic sensor_verdict_t classify_reading(int idx, int rd);
    sensor_verdict_t v;
    int thr;
    int sum;
    thr = (low_ext[idx] + high_ext[idx]) / 2;
    v.is_black = (rd > thr);
    v.threshold = thr[RBITS-1:0];
    // empty slots take the current extreme before summing
    for (int i = 0; i < DEPTH; i++) begin
      if (high_win[idx][i] == 0) high_win[idx][i] = high_ext[idx];
      if (low_win[idx][i] == 0) low_win[idx][i] = low_ext[idx];
    end
    sum = 0;
    if (rd >= thr) begin
      high_win[idx][high_slot[idx]] = rd;
      high_slot[idx] = (high_slot[idx] + 1 >= DEPTH) ? 0 : high_slot[idx] + 1;
      for (int i = 0; i < DEPTH; i++) sum += high_win[idx][i];
      high_ext[idx] = (high_ext[idx] + sum / DEPTH) / 2;
    end else begin
      low_win[idx][low_slot[idx]] = rd;
      low_slot[idx] = (low_slot[idx] + 1 >= DEPTH) ? 0 : low_slot[idx] + 1;
      for (int i = 0; i < DEPTH; i++) sum += low_win[idx][i];
      low_ext[idx] = (low_ext[idx] + sum / DEPTH) / 2;
    end
    black_flags[idx] = v.is_black;
    v.pattern = black_flags;
    v.changed = (black_flags != last_pattern);
    last_pattern = black_flags;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sensor_verdict_t want;
    if (!rst_ni) begin
      clear_sensor_state();
      predicted_verdicts.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_verdicts.size() == 0) begin
          $error("result with no request pending");
          fail_count_o++;
        end else begin
          want = predicted_verdicts.pop_front();
          if (is_black_i !== want.is_black) begin
            $error("is_black: expected %0d, got %0d", want.is_black, is_black_i);
            fail_count_o++;
          end
          if (threshold_used_i !== want.threshold) begin
            $error("threshold_used: expected %0d, got %0d", want.threshold, threshold_used_i);
            fail_count_o++;
          end
          if (sensor_pattern_i !== want.pattern) begin
            $error("sensor_pattern: expected %b, got %b", want.pattern, sensor_pattern_i);
            fail_count_o++;
          end
          if (pattern_changed_i !== want.changed) begin
            $error("pattern_changed: expected %0d, got %0d", want.changed, pattern_changed_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_verdicts.push_back(classify_reading(int'(sensor_index_i), int'(reading_i)));
      end
      pending_o = predicted_verdicts.size();
    end
  end

endmodule

### tb/tb_adaptive_line_sensor_classifier.sv
// testbench top for the adaptive line sensor classifier: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_adaptive_line_sensor_classifier;

  localparam int RBITS = alsc_pkg::READING_BITS_DEF;
  localparam logic [RBITS-1:0] MAX_READING = '1;
  localparam int RANDOM_REQUESTS = 1625;
  localparam int CALM_TAIL = 160;
  localparam int QUIET_LIMIT = 1000;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic [alsc_pkg::IDX_W-1:0] sensor_index_i = '0;
  logic [RBITS-1:0] reading_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  logic is_black_o;
  logic [RBITS-1:0] threshold_used_o;
  logic [alsc_pkg::PAT_W-1:0] sensor_pattern_o;
  logic pattern_changed_o;

  int fail_count;
  int pending;
  int quiet_cycles;
  bit tx_gaps_on = 1'b0;
  bit rx_stalls_on = 1'b0;

  adaptive_line_sensor_classifier dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sensor_index_i    (sensor_index_i),
    .reading_i         (reading_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .is_black_o        (is_black_o),
    .threshold_used_o  (threshold_used_o),
    .sensor_pattern_o  (sensor_pattern_o),
    .pattern_changed_o (pattern_changed_o)
  );

  alsc_verdict_checker verdict_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .sensor_index_i    (sensor_index_i),
    .reading_i         (reading_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .is_black_i        (is_black_o),
    .threshold_used_i  (threshold_used_o),
    .sensor_pattern_i  (sensor_pattern_o),
    .pattern_changed_i (pattern_changed_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls in random bursts
  initial begin : result_stalls
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input int idx, input logic [RBITS-1:0] rd);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    sensor_index_i = idx[alsc_pkg::IDX_W-1:0];
    reading_i = rd;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly readings near the thresholds, with empties and full scale mixed in
  function automatic logic [RBITS-1:0] pick_reading();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return MAX_READING;
      2, 3, 4: return RBITS'($urandom_range(0, 4095));
      5:       return RBITS'($urandom_range(1, 40));
      default: return RBITS'($urandom_range(200, 1700));
    endcase
  endfunction

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;

    // readings equal to the reset thresholds land in the high window
    send_request(0, 744);
    send_request(1, 608);
    send_request(2, 618);
    send_request(3, 815);
    // zero readings are stored and later refilled from the extreme
    send_request(0, '0);
    send_request(1, '0);
    send_request(2, '0);
    send_request(3, '0);
    send_request(0, '0);
    send_request(0, MAX_READING);
    send_request(1, MAX_READING);
    send_request(2, MAX_READING);
    send_request(3, MAX_READING);
    send_request(3, MAX_READING);
    send_request(2, 1);
    send_request(3, MAX_READING - RBITS'(1));
    send_request(0, 2048);
    send_request(1, 1);
    send_request(2, MAX_READING);
    send_request(3, '0);
    send_request(1, 12'hAAA);
    send_request(2, 12'h555);
    wait_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n >= RANDOM_REQUESTS - CALM_TAIL) begin
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
      end else if (n % 64 == 0) begin
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 299) == 0) wait_drained();
      send_request($urandom_range(0, 3), pick_reading());
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/alsc_pkg.sv
hw/rtl/alsc_ram.sv
hw/rtl/adaptive_line_sensor_classifier.sv
hw/rtl/alsc_checker.sv
tb/alsc_verdict_checker.sv
tb/tb_adaptive_line_sensor_classifier.sv
